### rtl/zcfm_pkg.sv
package zcfm_pkg;

  // Ring of frequency entries; depth must be a power of two (mean is a shift).
  localparam int AVG_DEPTH = 128;
  localparam int PTR_W     = $clog2(AVG_DEPTH);

  localparam int SAMPLE_W  = 16;
  localparam int HYST_W    = 15;
  localparam int FREQ_W    = 16;
  localparam int SUM_W     = FREQ_W + PTR_W;
  localparam int FRAC_W    = 8;
  localparam int AVG_W     = SUM_W + FRAC_W - PTR_W;

  // Result beat: pulse_level, new_measure, period_samples, freq_hz, avg_freq
  localparam int RES_W     = 2 + SAMPLE_W + FREQ_W + AVG_W;
  localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

  // Configuration registers
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_MIDPOINT    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HYSTERESIS  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_RATE = 2'd2;

  localparam logic [SAMPLE_W-1:0] MIDPOINT_RST    = 16'd32767;
  localparam logic [HYST_W-1:0]   HYSTERESIS_RST  = 15'd500;
  localparam logic [FREQ_W-1:0]   SAMPLE_RATE_RST = 16'd8000;

  localparam int DIV_STEPS = FREQ_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

endpackage

### rtl/zcfm_ram.sv
module zcfm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/zero_cross_frequency_meter.sv
// Channel   Dir  Signals                       Beat contents (lowest bit first)
// s_axis    in   s_axis_tvalid/tready/tdata    sample[15:0]
// m_axis    out  m_axis_tvalid/tready/tdata    pulse_level, new_measure,
//                                              period_samples[15:0], freq_hz[15:0],
//                                              avg_freq[23:0], zero pad
// cfg       in   cfg_we/cfg_addr/cfg_data      0 midpoint, 1 hysteresis, 2 sample_rate
//
// One sample in flight at a time. A sample with no falling crossing passes S_EVAL
// and S_OUT before the next accept; a falling crossing adds the bit-serial period
// divider plus one ring write-back. S_OUT holds while the last result is not taken.
// The frequency ring lives in a one-port-read RAM; entries not yet written since
// reset read as zero through a wrap flag, so reset needs no clearing pass.
// rst is synchronous; a new sample is taken while the previous result waits in
// the output register.
module zero_cross_frequency_meter
  import zcfm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // sample[15:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // pulse_level, new_measure,
                                                // period_samples, freq_hz, avg_freq
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_WB   = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]          state;

  logic [SAMPLE_W-1:0] midpoint;
  logic [HYST_W-1:0]   hysteresis;
  logic [FREQ_W-1:0]   sample_rate;

  logic [SAMPLE_W-1:0] cur;
  logic [SAMPLE_W-1:0] prev_sample;
  logic                armed;
  logic [SAMPLE_W-1:0] sample_count;
  logic [SAMPLE_W-1:0] last_period;
  logic [FREQ_W-1:0]   last_freq;
  logic                measured;
  logic [PTR_W-1:0]    ring_pointer;
  logic                wrapped;
  logic [SUM_W-1:0]    ring_sum;
  logic [FREQ_W-1:0]   old_entry;

  logic [FREQ_W-1:0]   div_rem;
  logic [FREQ_W-1:0]   div_quo;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic [FREQ_W-1:0]   ram_rdata;
  logic                ram_we;

  // thresholds, exact (no wrap)
  logic [SAMPLE_W:0]        thr_hi;
  logic signed [SAMPLE_W+1:0] thr_lo;
  logic                     rise_hit;
  logic                     fall_hit;

  always_comb begin
    thr_hi = {1'b0, midpoint} + {2'b0, hysteresis};
    thr_lo = $signed({2'b0, midpoint}) - $signed({3'b0, hysteresis});
    rise_hit = ({1'b0, cur} >= thr_hi) && ({1'b0, prev_sample} < thr_hi) && armed;
    fall_hit = ($signed({2'b0, cur}) <= thr_lo) && ($signed({2'b0, prev_sample}) > thr_lo)
               && !armed;
  end

  // restoring divider step; a zero divisor yields all ones, which is the saturated value
  logic [FREQ_W:0]   rem_sh;
  logic [FREQ_W+1:0] rem_diff;

  always_comb begin
    rem_sh   = {div_rem, div_quo[FREQ_W-1]};
    rem_diff = {1'b0, rem_sh} - {2'b0, last_period};
  end

  logic [FREQ_W-1:0] old_val;
  logic [SUM_W-1:0]  ring_sum_next;
  logic [SUM_W+FRAC_W-1:0] sum_scaled;
  logic [AVG_W-1:0]  avg_freq;

  always_comb begin
    old_val       = wrapped ? old_entry : '0;
    ring_sum_next = ring_sum - {{PTR_W{1'b0}}, old_val} + {{PTR_W{1'b0}}, div_quo};
    sum_scaled    = {ring_sum, {FRAC_W{1'b0}}};
    avg_freq      = sum_scaled[SUM_W+FRAC_W-1:PTR_W];
  end

  assign s_axis_tready = (state == S_IDLE);
  assign ram_we        = (state == S_WB);

  zcfm_ram #(
    .WIDTH (FREQ_W),
    .DEPTH (AVG_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ring_pointer),
    .wdata (div_quo),
    .raddr (ring_pointer),
    .rdata (ram_rdata)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      midpoint    <= MIDPOINT_RST;
      hysteresis  <= HYSTERESIS_RST;
      sample_rate <= SAMPLE_RATE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MIDPOINT:    midpoint    <= cfg_data;
        REG_HYSTERESIS:  hysteresis  <= cfg_data[HYST_W-1:0];
        REG_SAMPLE_RATE: sample_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_axis_tvalid) begin
      cur <= s_axis_tdata;
    end
    if (state == S_DIV && div_cnt == '0) begin
      old_entry <= ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      armed         <= 1'b0;
      prev_sample   <= '0;
      sample_count  <= '0;
      last_period   <= '0;
      last_freq     <= '0;
      measured      <= 1'b0;
      ring_pointer  <= '0;
      wrapped       <= 1'b0;
      ring_sum      <= '0;
      div_rem       <= '0;
      div_quo       <= '0;
      div_cnt       <= '0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
    end else begin
      // in S_OUT the output register is reloaded below instead
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          prev_sample <= cur;
          measured    <= fall_hit;
          if (rise_hit) begin
            armed <= 1'b0;
          end
          if (fall_hit) begin
            // count restarts; this sample already counts as one
            last_period  <= sample_count;
            sample_count <= {{(SAMPLE_W-1){1'b0}}, 1'b1};
            armed        <= 1'b1;
            div_rem      <= '0;
            div_quo      <= sample_rate;
            div_cnt      <= '0;
            state        <= S_DIV;
          end else begin
            if (sample_count != '1) begin
              sample_count <= sample_count + 1'b1;
            end
            state <= S_OUT;
          end
        end
        S_DIV: begin
          if (!rem_diff[FREQ_W+1]) begin
            div_rem <= rem_diff[FREQ_W-1:0];
          end else begin
            div_rem <= rem_sh[FREQ_W-1:0];
          end
          div_quo <= {div_quo[FREQ_W-2:0], !rem_diff[FREQ_W+1]};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state <= S_WB;
          end
        end
        S_WB: begin
          last_freq <= div_quo;
          ring_sum  <= ring_sum_next;
          if (ring_pointer == PTR_W'(AVG_DEPTH - 1)) begin
            ring_pointer <= '0;
            wrapped      <= 1'b1;
          end else begin
            ring_pointer <= ring_pointer + 1'b1;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {{(OUT_DATA_W-RES_W){1'b0}}, avg_freq, last_freq,
                              last_period, measured, armed};
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a completed measurement always leaves the output level high
  a_measure_sets_level: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
    else $error("new_measure without pulse_level");

  // ring write-back is always followed by delivering the result
  a_wb_to_out: assert property (@(posedge clk) disable iff (rst)
    state == S_WB |=> state == S_OUT)
    else $error("write-back not followed by output");

  // the divider runs only after a falling crossing
  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_DIV) |-> $past(state == S_EVAL) && armed)
    else $error("divider started without a falling crossing");

  // the wrap flag sets exactly when the pointer returns to zero
  a_wrap_at_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(wrapped) |-> ring_pointer == '0)
    else $error("wrap flag set away from ring start");

  // the running sum only changes on a ring write-back
  a_sum_only_on_wb: assert property (@(posedge clk) disable iff (rst)
    !$stable(ring_sum) |-> $past(state == S_WB) || $past(rst))
    else $error("ring sum changed outside write-back");
`endif

endmodule

### test/meter_checker.sv
module meter_checker
  import zcfm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_valid,
  input  logic                  s_ready,
  input  logic [SAMPLE_W-1:0]   s_data,
  input  logic                  m_valid,
  input  logic                  m_ready,
  input  logic [OUT_DATA_W-1:0] m_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    miscompares,
  output int                    readings_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  // pulse_level sits in bit 0 of the beat, so it is the last (lowest) member here
  typedef struct packed {
    logic [AVG_W-1:0]    avg_freq;
    logic [FREQ_W-1:0]   freq_hz;
    logic [SAMPLE_W-1:0] period_samples;
    logic                new_measure;
    logic                pulse_level;
  } reading_t;

  logic [SAMPLE_W-1:0] mid_reg;
  logic [HYST_W-1:0]   hyst_reg;
  logic [FREQ_W-1:0]   rate_reg;

  logic                armed_high;
  logic [SAMPLE_W-1:0] prev_sample;
  logic [SAMPLE_W-1:0] sample_count;
  logic [SAMPLE_W-1:0] last_period;
  logic [FREQ_W-1:0]   last_freq;
  logic [FREQ_W-1:0]   freq_ring [AVG_DEPTH];
  logic [PTR_W-1:0]    ring_ptr;
  logic [SUM_W-1:0]    ring_total;

  reading_t readings_due [$];
  int       beat_idx;

  function automatic reading_t next_reading(input logic [SAMPLE_W-1:0] smp);
    int                      cur;
    int                      prev;
    int                      hi_lvl;
    int                      lo_lvl;
    logic                    fell;
    logic [SUM_W+FRAC_W-1:0] scaled;
    reading_t                r;
    cur    = smp;
    prev   = prev_sample;
    hi_lvl = mid_reg;
    lo_lvl = mid_reg;
    hi_lvl = hi_lvl + hyst_reg;
    lo_lvl = lo_lvl - hyst_reg;
    fell   = 1'b0;
    // thresholds are exact ints: out-of-range levels simply never match
    if (cur >= hi_lvl && prev < hi_lvl && armed_high) begin
      armed_high = 1'b0;
    end else if (cur <= lo_lvl && prev > lo_lvl && !armed_high) begin
      last_period = sample_count;
      last_freq   = (sample_count == '0) ? '1 : rate_reg / sample_count;
      ring_total  = ring_total - freq_ring[ring_ptr] + last_freq;
      freq_ring[ring_ptr] = last_freq;
      ring_ptr     = ring_ptr + 1'b1;  // depth is a power of two, wraps by itself
      sample_count = '0;
      armed_high   = 1'b1;
      fell         = 1'b1;
    end
    prev_sample = smp;
    if (sample_count != '1) sample_count = sample_count + 1'b1;
    scaled = {ring_total, {FRAC_W{1'b0}}};
    r.avg_freq       = AVG_W'(scaled >> PTR_W);
    r.freq_hz        = last_freq;
    r.period_samples = last_period;
    r.new_measure    = fell;
    r.pulse_level    = armed_high;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    reading_t got;
    reading_t want;
    if (rst) begin
      mid_reg      = MIDPOINT_RST;
      hyst_reg     = HYSTERESIS_RST;
      rate_reg     = SAMPLE_RATE_RST;
      armed_high   = 1'b0;
      prev_sample  = '0;
      sample_count = '0;
      last_period  = '0;
      last_freq    = '0;
      for (int i = 0; i < AVG_DEPTH; i++) freq_ring[i] = '0;
      ring_ptr     = '0;
      ring_total   = '0;
      readings_due.delete();
      beat_idx      = 0;
      miscompares   = 0;
      readings_owed = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_MIDPOINT:    mid_reg  = cfg_data;
          REG_HYSTERESIS:  hyst_reg = cfg_data[HYST_W-1:0];
          REG_SAMPLE_RATE: rate_reg = cfg_data;
          default: ;
        endcase
      end
      if (m_valid && m_ready) begin
        if (readings_due.size() == 0) begin
          if (miscompares < 10)
            $display("%t result beat %0d arrived with no sample outstanding", $time, beat_idx);
          miscompares++;
        end else begin
          want = readings_due.pop_front();
          got  = m_data[RES_W-1:0];
          if (got !== want || m_data[OUT_DATA_W-1:RES_W] !== '0) begin
            if (miscompares < 10) begin
              $write("%t beat %0d: expected pulse %0b new %0b period %0d freq %0d avg %0h",
                     $time, beat_idx, want.pulse_level, want.new_measure,
                     want.period_samples, want.freq_hz, want.avg_freq);
              $display(" / got pulse %0b new %0b period %0d freq %0d avg %0h pad %0h",
                       got.pulse_level, got.new_measure, got.period_samples,
                       got.freq_hz, got.avg_freq, m_data[OUT_DATA_W-1:RES_W]);
            end
            miscompares++;
          end
        end
        beat_idx++;
      end
      if (s_valid && s_ready) readings_due.push_back(next_reading(s_data));
      readings_owed = readings_due.size();
    end
  end

endmodule

### test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import zcfm_pkg::*;

  // unmapped register index; the block must ignore writes to it
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;

  localparam int OPENING_N = 12;
  // default thresholds are 33267 (rise) and 32267 (fall)
  localparam logic [SAMPLE_W-1:0] OPENING [OPENING_N] = '{
    16'd65535, 16'd0, 16'd65535, 16'd0, 16'd33267, 16'd32267,
    16'd33266, 16'd33267, 16'd32268, 16'd32267, 16'd0, 16'd32767
  };

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [SAMPLE_W-1:0]   s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int cur_mid;
  int cur_hyst;
  bit no_idle;
  int hold_go;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  zero_cross_frequency_meter dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  meter_checker watch (
    .clk           (clk),
    .rst           (rst),
    .s_valid       (s_axis_tvalid),
    .s_ready       (s_axis_tready),
    .s_data        (s_axis_tdata),
    .m_valid       (m_axis_tvalid),
    .m_ready       (m_axis_tready),
    .m_data        (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .miscompares   (fail_count),
    .readings_owed (pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // receive side; a bump of hold_go forces a long back-pressure stretch
  initial begin : rx_side
    int hold;
    int seen_go;
    int r;
    hold          = 0;
    seen_go       = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go != seen_go) begin
        seen_go = hold_go;
        hold    = 300;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (no_idle) begin
        m_axis_tready <= 1'b1;
      end else begin
        r = $urandom_range(99, 0);
        if (r < 60) begin
          m_axis_tready <= 1'b1;
        end else if (r < 92) begin
          m_axis_tready <= 1'b0;
          hold = $urandom_range(2, 0);
        end else begin
          m_axis_tready <= 1'b0;
          hold = $urandom_range(40, 6);
        end
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic push_sample(input logic [SAMPLE_W-1:0] v);
    int g;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    g = pick_gap();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    case (idx)
      REG_MIDPOINT:   cur_mid  = val;
      REG_HYSTERESIS: cur_hyst = val[HYST_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // square-ish wave around the current thresholds: runs of high and low samples,
  // some landing right at a threshold, some pure noise
  task automatic send_wave(input int count);
    logic                upper;
    int                  run;
    int                  hi_c;
    int                  lo_c;
    int                  r;
    logic [SAMPLE_W-1:0] v;
    upper = 1'($urandom_range(1, 0));
    run   = 0;
    hi_c  = cur_mid + cur_hyst;
    lo_c  = cur_mid - cur_hyst;
    if (hi_c > 65535) hi_c = 65535;
    if (lo_c < 0) lo_c = 0;
    for (int k = 0; k < count; k++) begin
      if (run == 0) begin
        upper = !upper;
        run   = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 8) : $urandom_range(4, 1);
      end
      run--;
      r = $urandom_range(99, 0);
      if (r < 80) begin
        v = SAMPLE_W'(upper ? $urandom_range(65535, hi_c) : $urandom_range(lo_c, 0));
      end else if (r < 90) begin
        case ($urandom_range(3, 0))
          0:       v = SAMPLE_W'(hi_c - 1);
          1:       v = SAMPLE_W'(hi_c);
          2:       v = SAMPLE_W'(lo_c);
          default: v = SAMPLE_W'(lo_c + 1);
        endcase
      end else begin
        v = SAMPLE_W'($urandom);
      end
      push_sample(v);
    end
  endtask

  task automatic run_phase(input logic [15:0] mid, input logic [15:0] hyst,
                           input logic [15:0] rate, input int count, input bit press);
    settle();
    write_reg(REG_MIDPOINT, mid);
    write_reg(REG_HYSTERESIS, hyst);
    write_reg(REG_SAMPLE_RATE, rate);
    cfg_we <= 1'b0;
    if (press) begin
      no_idle = 1'b1;
      hold_go++;
    end
    send_wave(count);
    no_idle = 1'b0;
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_data      = '0;
    cur_mid       = MIDPOINT_RST;
    cur_hyst      = HYSTERESIS_RST;
    no_idle       = 1'b0;
    hold_go       = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // crossings exactly at and one step off each threshold, first period of one
    for (int k = 0; k < OPENING_N; k++) push_sample(OPENING[k]);

    settle();
    write_reg(REG_SPARE, 16'hFFFF);
    cfg_we <= 1'b0;

    // threshold extremes: zero band, unreachable levels, zero rate, masked write
    run_phase(16'd0,     16'd0,     16'hFFFF,  100, 1'b0);
    run_phase(16'hFFFF,  16'hFFFF,  16'd1,     100, 1'b0);
    run_phase(16'd0,     16'h7FFF,  16'd0,     100, 1'b0);
    run_phase(16'h8000,  16'd0,     16'hFFFF,  120, 1'b0);
    run_phase(16'hFFFF,  16'd0,     16'd12345,  80, 1'b0);
    for (int p = 0; p < 3; p++)
      run_phase(16'($urandom_range(57000, 8000)), 16'($urandom_range(6000, 0)),
                16'($urandom_range(65535, 1)), 150, 1'b0);
    run_phase(16'($urandom_range(50000, 15000)), 16'($urandom_range(3000, 100)),
              16'($urandom_range(65535, 1)), 200, 1'b1);

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("status: fail");
    $finish;
  end

endmodule
